[src/dqnp_pkg.sv]
// Shared types and constants for the DNS question name parser.
// No dependencies; imported by dqnp_walker, the top level and the checker.
`default_nettype none

package dqnp_pkg;

   localparam int HEADER_BYTES = 12;
   localparam int QDCOUNT_HI   = 4;
   localparam int QDCOUNT_LO   = 5;
   localparam int MAX_CHUNKS   = 32;
   localparam int CHUNK_CHARS  = 8;
   localparam int TYPE_CLASS_BYTES = 4;
   localparam logic [1:0] PTR_TAG   = 2'b11;
   localparam logic [1:0] LABEL_TAG = 2'b00;
   localparam logic [7:0] DOT_CHAR  = 8'h2E;

   typedef enum logic [1:0] {
      ST_OK,
      ST_BAD_HEADER,
      ST_BAD_NAME,
      ST_TRUNCATED
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_HDR_LEN,
      S_HDR_RD5,
      S_HDR_LO,
      S_LBL_REQ,
      S_LBL,
      S_PTR,
      S_COPY,
      S_TAIL,
      S_QT_RD1,
      S_QT_LO,
      S_NAME_RD,
      S_NAME_CAP,
      S_OUT,
      S_ERR
   } state_type;

   typedef struct packed {
      logic        strobe;
      logic [63:0] name_chunk;
      logic [3:0]  chunk_bytes;
      logic        final_res;
      status_type  status;
      logic [15:0] query_type;
      logic [11:0] question_end;
   } rsp_type;

endpackage

`default_nettype wire

[src/dqnp_packet_store.sv]
// Message byte store: one write port, one registered read port.
// Depends on nothing outside this file.
`default_nettype none

module dqnp_packet_store #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [7:0]    wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [7:0]    rdata
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

[src/dqnp_name_store.sv]
// Decoded name store: lowercases ASCII letters on write, registered read.
// Depends on nothing outside this file.
`default_nettype none

module dqnp_name_store #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [7:0]    wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [7:0]    rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] lower_char;

   always_comb begin
      lower_char = wdata;
      if (wdata >= 8'h41 && wdata <= 8'h5A) begin
         lower_char = wdata + 8'h20;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= lower_char;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

[src/dqnp_walker.sv]
// Sequencer: loads message bytes, checks the header, walks labels and pointers,
// and emits the name in chunks. Uses dqnp_pkg; drives both stores.
`default_nettype none

module dqnp_walker #(
   parameter int PACKET_BYTES  = 2048,
   parameter int NAME_CAPACITY = 256,
   parameter int JUMP_LIMIT    = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic last_byte,
   output logic busy,
   output logic pkt_we,
   output logic [$clog2(PACKET_BYTES)-1:0] pkt_waddr,
   output logic [$clog2(PACKET_BYTES)-1:0] pkt_raddr,
   input  wire logic [7:0] pkt_rdata,
   output logic name_we,
   output logic [$clog2(NAME_CAPACITY)-1:0] name_waddr,
   output logic [7:0] name_wdata,
   output logic [$clog2(NAME_CAPACITY)-1:0] name_raddr,
   input  wire logic [7:0] name_rdata,
   output dqnp_pkg::rsp_type rsp
);

   import dqnp_pkg::*;

   localparam int AW  = $clog2(PACKET_BYTES);
   localparam int CW  = $clog2(PACKET_BYTES + 1);
   localparam int OW  = ((CW > 14) ? CW : 14) + 1;
   localparam int NAW = $clog2(NAME_CAPACITY);
   localparam int NLW = $clog2(NAME_CAPACITY + 1);
   localparam int NCW = NLW + 7;
   localparam int BW  = NLW + 1;
   localparam int JW  = $clog2(JUMP_LIMIT + 1);

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [OW-1:0]  woff_ff, woff_in;
   logic [OW-1:0]  after_ff, after_in;
   logic           have_after_ff, have_after_in;
   logic [JW-1:0]  jumps_ff, jumps_in;
   logic [NLW-1:0] n_ff, n_in;
   logic [5:0]     lcnt_ff, lcnt_in;
   logic           pend_ff, pend_in;
   logic [7:0]     tmp_ff, tmp_in;
   logic [15:0]    qt_ff, qt_in;
   status_type     status_ff, status_in;
   logic [NLW-1:0] base_ff, base_in;
   logic [4:0]     k_ff, k_in;
   logic [2:0]     pos_ff, pos_in;
   logic [63:0]    word_ff, word_in;

   logic [OW-1:0]  len_ext;
   logic [OW-1:0]  woff_inc;
   logic [NLW-1:0] rem;
   logic [3:0]     cnt4;
   logic           last_chunk;
   logic [11:0]    qend;

   assign len_ext    = {{(OW-CW){1'b0}}, count_ff};
   assign woff_inc   = woff_ff + OW'(1);
   assign rem        = n_ff - base_ff;
   assign cnt4       = (rem > NLW'(CHUNK_CHARS)) ? 4'(CHUNK_CHARS) : rem[3:0];
   assign last_chunk = (BW'(base_ff) + BW'(CHUNK_CHARS) >= BW'(n_ff))
                       || (k_ff == 5'(MAX_CHUNKS - 1));
   assign qend       = 12'(after_ff + OW'(TYPE_CLASS_BYTES));
   assign busy       = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      woff_ff       <= woff_in;
      after_ff      <= after_in;
      have_after_ff <= have_after_in;
      jumps_ff      <= jumps_in;
      n_ff          <= n_in;
      lcnt_ff       <= lcnt_in;
      tmp_ff        <= tmp_in;
      qt_ff         <= qt_in;
      status_ff     <= status_in;
      base_ff       <= base_in;
      k_ff          <= k_in;
      pos_ff        <= pos_in;
      word_ff       <= word_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      woff_in       = woff_ff;
      after_in      = after_ff;
      have_after_in = have_after_ff;
      jumps_in      = jumps_ff;
      n_in          = n_ff;
      lcnt_in       = lcnt_ff;
      pend_in       = pend_ff;
      tmp_in        = tmp_ff;
      qt_in         = qt_ff;
      status_in     = status_ff;
      base_in       = base_ff;
      k_in          = k_ff;
      pos_in        = pos_ff;
      word_in       = word_ff;
      pkt_we        = 1'b0;
      pkt_waddr     = count_ff[AW-1:0];
      pkt_raddr     = woff_ff[AW-1:0];
      name_we       = 1'b0;
      name_waddr    = n_ff[NAW-1:0];
      name_wdata    = pkt_rdata;
      name_raddr    = NAW'(base_ff + NLW'(pos_ff));
      rsp           = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (count_ff < CW'(PACKET_BYTES)) begin
                  pkt_we   = 1'b1;
                  count_in = count_ff + CW'(1);
               end
               if (last_byte) begin
                  state_in = S_HDR_LEN;
               end
            end
         end
         S_HDR_LEN: begin
            pkt_raddr = AW'(QDCOUNT_HI);
            if (count_ff < CW'(HEADER_BYTES)) begin
               status_in = ST_BAD_HEADER;
               state_in  = S_ERR;
            end else begin
               state_in = S_HDR_RD5;
            end
         end
         S_HDR_RD5: begin
            tmp_in    = pkt_rdata;
            pkt_raddr = AW'(QDCOUNT_LO);
            state_in  = S_HDR_LO;
         end
         S_HDR_LO: begin
            if (tmp_ff == 8'h00 && pkt_rdata == 8'h00) begin
               status_in = ST_BAD_HEADER;
               state_in  = S_ERR;
            end else begin
               woff_in       = OW'(HEADER_BYTES);
               jumps_in      = '0;
               n_in          = '0;
               have_after_in = 1'b0;
               state_in      = S_LBL_REQ;
            end
         end
         S_LBL_REQ: begin
            if (woff_ff >= len_ext) begin
               status_in = ST_BAD_NAME;
               state_in  = S_ERR;
            end else begin
               state_in = S_LBL;
            end
         end
         S_LBL: begin
            if (pkt_rdata == 8'h00) begin
               if (!have_after_ff) begin
                  after_in = woff_inc;
               end
               if (n_ff == '0) begin
                  name_we    = 1'b1;
                  name_wdata = DOT_CHAR;
                  n_in       = NLW'(1);
               end else if (n_ff > NLW'(1)) begin
                  n_in = n_ff - NLW'(1);
               end
               state_in = S_TAIL;
            end else if (pkt_rdata[7:6] == PTR_TAG) begin
               pkt_raddr = woff_inc[AW-1:0];
               if (woff_inc >= len_ext || jumps_ff == JW'(JUMP_LIMIT)) begin
                  status_in = ST_BAD_NAME;
                  state_in  = S_ERR;
               end else begin
                  jumps_in = jumps_ff + JW'(1);
                  if (!have_after_ff) begin
                     after_in      = woff_ff + OW'(2);
                     have_after_in = 1'b1;
                  end
                  tmp_in   = pkt_rdata;
                  state_in = S_PTR;
               end
            end else if (pkt_rdata[7:6] != LABEL_TAG
                         || woff_inc + OW'(pkt_rdata) > len_ext
                         || NCW'(n_ff) + NCW'(pkt_rdata) + NCW'(2)
                            >= NCW'(NAME_CAPACITY)) begin
               status_in = ST_BAD_NAME;
               state_in  = S_ERR;
            end else begin
               lcnt_in  = pkt_rdata[5:0];
               woff_in  = woff_inc;
               pend_in  = 1'b0;
               state_in = S_COPY;
            end
         end
         S_PTR: begin
            woff_in  = OW'({tmp_ff[5:0], pkt_rdata});
            state_in = S_LBL_REQ;
         end
         S_COPY: begin
            if (pend_ff) begin
               name_we    = 1'b1;
               name_wdata = pkt_rdata;
               n_in       = n_ff + NLW'(1);
            end
            if (lcnt_ff != 6'd0) begin
               woff_in = woff_inc;
               lcnt_in = lcnt_ff - 6'd1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  name_we    = 1'b1;
                  name_wdata = DOT_CHAR;
                  n_in       = n_ff + NLW'(1);
                  state_in   = S_LBL_REQ;
               end
            end
         end
         S_TAIL: begin
            pkt_raddr = after_ff[AW-1:0];
            if (after_ff + OW'(TYPE_CLASS_BYTES) > len_ext) begin
               status_in = ST_TRUNCATED;
               state_in  = S_ERR;
            end else begin
               state_in = S_QT_RD1;
            end
         end
         S_QT_RD1: begin
            qt_in[15:8] = pkt_rdata;
            pkt_raddr   = AW'(after_ff + OW'(1));
            state_in    = S_QT_LO;
         end
         S_QT_LO: begin
            qt_in[7:0] = pkt_rdata;
            base_in    = '0;
            k_in       = '0;
            pos_in     = '0;
            word_in    = '0;
            state_in   = S_NAME_RD;
         end
         S_NAME_RD: begin
            state_in = S_NAME_CAP;
         end
         S_NAME_CAP: begin
            word_in[{pos_ff, 3'b000} +: 8] = name_rdata;
            if ({1'b0, pos_ff} == cnt4 - 4'd1) begin
               state_in = S_OUT;
            end else begin
               pos_in   = pos_ff + 3'd1;
               state_in = S_NAME_RD;
            end
         end
         S_OUT: begin
            rsp.strobe      = 1'b1;
            rsp.name_chunk  = word_ff;
            rsp.chunk_bytes = cnt4;
            rsp.status      = ST_OK;
            if (last_chunk) begin
               rsp.final_res    = 1'b1;
               rsp.query_type   = qt_ff;
               rsp.question_end = qend;
               count_in         = '0;
               state_in         = S_IDLE;
            end else begin
               base_in  = base_ff + NLW'(CHUNK_CHARS);
               k_in     = k_ff + 5'd1;
               pos_in   = '0;
               word_in  = '0;
               state_in = S_NAME_RD;
            end
         end
         S_ERR: begin
            rsp.strobe    = 1'b1;
            rsp.final_res = 1'b1;
            rsp.status    = status_ff;
            count_in      = '0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[src/dns_question_name_parser_unit.sv]
// DNS question name parser, top level: sequencer plus packet and name stores.
// Depends on dqnp_pkg, dqnp_walker, dqnp_packet_store and dqnp_name_store.
//
// Load a DNS message one byte per transaction (start high while busy is low),
// one byte per cycle, flagging the final byte with req_last_byte; bytes past
// PACKET_BYTES are dropped. After the final byte busy stays high while the
// sequencer parses out of the packet memory, whose single read port sets the
// pace: the header check, each label and its characters, each compression
// pointer, the terminating zero and the type field, then each name
// character read back and each chunk emitted. Results appear on the rsp_
// ports for one cycle each, marked by rsp_strobe; the receiver cannot
// stall them. The last result has rsp_final_res set; an error gives a
// single result with the status code.
`default_nettype none

module dns_question_name_parser_unit #(
   parameter int PACKET_BYTES  = 2048,
   parameter int NAME_CAPACITY = 256,
   parameter int JUMP_LIMIT    = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_pkt_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_strobe,
   output logic [63:0]      rsp_name_chunk,
   output logic [3:0]       rsp_chunk_bytes,
   output logic             rsp_final_res,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_query_type,
   output logic [11:0]      rsp_question_end
);

   import dqnp_pkg::*;

   localparam int AW  = $clog2(PACKET_BYTES);
   localparam int NAW = $clog2(NAME_CAPACITY);

   logic           pkt_we;
   logic [AW-1:0]  pkt_waddr;
   logic [AW-1:0]  pkt_raddr;
   logic [7:0]     pkt_rdata;
   logic           name_we;
   logic [NAW-1:0] name_waddr;
   logic [7:0]     name_wdata;
   logic [NAW-1:0] name_raddr;
   logic [7:0]     name_rdata;
   rsp_type        rsp;

   dqnp_walker #(
      .PACKET_BYTES  (PACKET_BYTES),
      .NAME_CAPACITY (NAME_CAPACITY),
      .JUMP_LIMIT    (JUMP_LIMIT)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .last_byte  (req_last_byte),
      .busy       (busy),
      .pkt_we     (pkt_we),
      .pkt_waddr  (pkt_waddr),
      .pkt_raddr  (pkt_raddr),
      .pkt_rdata  (pkt_rdata),
      .name_we    (name_we),
      .name_waddr (name_waddr),
      .name_wdata (name_wdata),
      .name_raddr (name_raddr),
      .name_rdata (name_rdata),
      .rsp        (rsp)
   );

   dqnp_packet_store #(
      .DEPTH (PACKET_BYTES),
      .AW    (AW)
   ) u_packet_store (
      .clock (clock),
      .we    (pkt_we),
      .waddr (pkt_waddr),
      .wdata (req_pkt_byte),
      .raddr (pkt_raddr),
      .rdata (pkt_rdata)
   );

   dqnp_name_store #(
      .DEPTH (NAME_CAPACITY),
      .AW    (NAW)
   ) u_name_store (
      .clock (clock),
      .we    (name_we),
      .waddr (name_waddr),
      .wdata (name_wdata),
      .raddr (name_raddr),
      .rdata (name_rdata)
   );

   assign rsp_strobe       = rsp.strobe;
   assign rsp_name_chunk   = rsp.name_chunk;
   assign rsp_chunk_bytes  = rsp.chunk_bytes;
   assign rsp_final_res    = rsp.final_res;
   assign rsp_status       = rsp.status;
   assign rsp_query_type   = rsp.query_type;
   assign rsp_question_end = rsp.question_end;

endmodule

`default_nettype wire

[src/dqnp_checker.sv]
// Port-level checks for dns_question_name_parser_unit, bound to the top level.
// Depends on dqnp_pkg for the status codes.
`default_nettype none

module dqnp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        req_last_byte,
   input wire logic        rsp_strobe,
   input wire logic [63:0] rsp_name_chunk,
   input wire logic [3:0]  rsp_chunk_bytes,
   input wire logic        rsp_final_res,
   input wire logic [1:0]  rsp_status
);

   import dqnp_pkg::*;

   a_last_byte_starts_parse: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_byte |=> busy)
      else $error("parse did not start after final byte");

   a_no_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobed while idle");

   a_more_chunks_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_final_res |=> busy && !rsp_strobe)
      else $error("non-final chunk not followed by further work");

   a_final_releases: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_final_res |=> !busy)
      else $error("block still busy after final result");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |->
         rsp_final_res && rsp_chunk_bytes == 4'd0 && rsp_name_chunk == 64'd0)
      else $error("error result not a single empty final result");

endmodule

bind dns_question_name_parser_unit dqnp_checker u_dqnp_checker (.*);

`default_nettype wire

[tb/dns_question_name_parser_unit_tb.sv]
// Self-checking testbench for dns_question_name_parser_unit: feeds DNS messages byte by byte,
// decodes each question name on its own and compares every result chunk in order.
// Depends on dqnp_pkg and the dns_question_name_parser_unit RTL.
`timescale 1ns / 100ps

module dns_question_name_parser_unit_tb;
   import dqnp_pkg::*;

   localparam int PACKET_BYTES   = 2048;
   localparam int NAME_CAPACITY  = 256;
   localparam int JUMP_LIMIT     = 16;
   localparam int MAX_LABEL_LEN  = 63;
   localparam int IDLE_LIMIT     = 20000;
   localparam int TAIL_CYCLES    = 64;
   localparam int RANDOM_BYTES   = 130;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [63:0] chunk;
      logic [3:0]  nbytes;
      logic        last_chunk;
      status_type  status;
      logic [15:0] qtype;
      logic [11:0] qend;
   } name_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [7:0]  req_pkt_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        busy;
   logic        rsp_strobe;
   logic [63:0] rsp_name_chunk;
   logic [3:0]  rsp_chunk_bytes;
   logic        rsp_final_res;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_query_type;
   logic [11:0] rsp_question_end;

   bit [7:0]        wire_bytes [PACKET_BYTES];
   int              stored_count = 0;
   name_result_type expected_chunks [$];
   name_result_type head_result;
   bit [7:0]        msg_bytes [$];
   int              max_gap = 6;
   int              fail_count = 0;
   int              quiet_cycles = 0;

   dns_question_name_parser_unit #(
      .PACKET_BYTES (PACKET_BYTES),
      .NAME_CAPACITY(NAME_CAPACITY),
      .JUMP_LIMIT   (JUMP_LIMIT)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_pkt_byte    (req_pkt_byte),
      .req_last_byte   (req_last_byte),
      .rsp_strobe      (rsp_strobe),
      .rsp_name_chunk  (rsp_name_chunk),
      .rsp_chunk_bytes (rsp_chunk_bytes),
      .rsp_final_res   (rsp_final_res),
      .rsp_status      (rsp_status),
      .rsp_query_type  (rsp_query_type),
      .rsp_question_end(rsp_question_end)
   );

   always #4 clock = ~clock;

   function automatic void push_error(status_type code);
      name_result_type r;
      r = '0;
      r.last_chunk = 1'b1;
      r.status = code;
      expected_chunks.push_back(r);
   endfunction

   function automatic void decode_question(int len);
      bit [7:0]        name_buf [NAME_CAPACITY];
      bit [7:0]        label_byte;
      bit [7:0]        c;
      int              pos, n, after, jumps, nchunks, cnt, i, k;
      bit              have_after, done, ok;
      name_result_type r;
      if (len < HEADER_BYTES || {wire_bytes[QDCOUNT_HI], wire_bytes[QDCOUNT_LO]} == 16'd0) begin
         push_error(ST_BAD_HEADER);
         return;
      end
      pos = HEADER_BYTES;
      n = 0;
      after = 0;
      jumps = 0;
      have_after = 1'b0;
      done = 1'b0;
      ok = 1'b0;
      while (!done && pos < len) begin
         label_byte = wire_bytes[pos];
         if (label_byte == 8'd0) begin
            if (!have_after) after = pos + 1;
            if (n == 0) begin
               name_buf[0] = DOT_CHAR;
               n = 1;
            end else if (n > 1) begin
               n--;
            end
            ok = 1'b1;
            done = 1'b1;
         end else if (label_byte[7:6] == PTR_TAG) begin
            jumps++;
            if (pos + 1 >= len || jumps > JUMP_LIMIT) begin
               done = 1'b1;
            end else begin
               if (!have_after) begin
                  after = pos + 2;
                  have_after = 1'b1;
               end
               pos = {label_byte[5:0], wire_bytes[pos + 1]};
            end
         end else if (label_byte > MAX_LABEL_LEN || pos + 1 + label_byte > len ||
                      n + label_byte + 2 >= NAME_CAPACITY) begin
            done = 1'b1;
         end else begin
            for (i = 0; i < label_byte; i++) begin
               c = wire_bytes[pos + 1 + i];
               if (c >= "A" && c <= "Z") c = c + 8'd32;
               name_buf[n + i] = c;
            end
            n += label_byte;
            name_buf[n] = DOT_CHAR;
            n++;
            pos += label_byte + 1;
         end
      end
      if (!ok) begin
         push_error(ST_BAD_NAME);
      end else if (after + TYPE_CLASS_BYTES > len) begin
         push_error(ST_TRUNCATED);
      end else begin
         nchunks = (n + CHUNK_CHARS - 1) / CHUNK_CHARS;
         if (nchunks > MAX_CHUNKS) nchunks = MAX_CHUNKS;
         for (k = 0; k < nchunks; k++) begin
            r = '0;
            cnt = n - k * CHUNK_CHARS;
            if (cnt > CHUNK_CHARS) cnt = CHUNK_CHARS;
            for (i = 0; i < cnt; i++) r.chunk[8 * i +: 8] = name_buf[k * CHUNK_CHARS + i];
            r.nbytes = 4'(cnt);
            r.status = ST_OK;
            if (k == nchunks - 1) begin
               r.last_chunk = 1'b1;
               r.qtype = {wire_bytes[after], wire_bytes[after + 1]};
               r.qend = 12'(after + TYPE_CLASS_BYTES);
            end
            expected_chunks.push_back(r);
         end
      end
   endfunction

   // Drop bytes past the store; the flagged byte still triggers the decode.
   function automatic void record_byte(bit [7:0] value, bit last);
      if (stored_count < PACKET_BYTES) begin
         wire_bytes[stored_count] = value;
         stored_count++;
      end
      if (last) begin
         decode_question(stored_count);
         stored_count = 0;
      end
   endfunction

   function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_chunks.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("%0t: unexpected result, chunk %h bytes %0d final %b status %0d",
                        $time, rsp_name_chunk, rsp_chunk_bytes, rsp_final_res, rsp_status);
         end else begin
            head_result = expected_chunks.pop_front();
            compare_field("name_chunk", head_result.chunk, rsp_name_chunk);
            compare_field("chunk_bytes", head_result.nbytes, rsp_chunk_bytes);
            compare_field("final_res", head_result.last_chunk, rsp_final_res);
            compare_field("status", head_result.status, rsp_status);
            compare_field("query_type", head_result.qtype, rsp_query_type);
            compare_field("question_end", head_result.qend, rsp_question_end);
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("dns_question_name_parser_unit_tb failed");
         $finish;
      end
   end

   function automatic bit [7:0] rand_char();
      case ($urandom_range(0, 3))
         0: return "A" + 8'($urandom_range(0, 25));
         1: return "a" + 8'($urandom_range(0, 25));
         2: return "0" + 8'($urandom_range(0, 9));
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void start_message(bit [15:0] qdcount);
      msg_bytes.delete();
      repeat (QDCOUNT_HI) msg_bytes.push_back(8'($urandom));
      msg_bytes.push_back(qdcount[15:8]);
      msg_bytes.push_back(qdcount[7:0]);
      repeat (HEADER_BYTES - QDCOUNT_LO - 1) msg_bytes.push_back(8'($urandom));
   endfunction

   function automatic void add_raw(bit [7:0] value);
      msg_bytes.push_back(value);
   endfunction

   function automatic void add_label(string text);
      msg_bytes.push_back(8'(text.len()));
      for (int i = 0; i < text.len(); i++) msg_bytes.push_back(text[i]);
   endfunction

   function automatic void add_random_label(int len);
      msg_bytes.push_back(8'(len));
      repeat (len) msg_bytes.push_back(rand_char());
   endfunction

   function automatic void add_pointer(bit [13:0] offset);
      msg_bytes.push_back({PTR_TAG, offset[13:8]});
      msg_bytes.push_back(offset[7:0]);
   endfunction

   function automatic void add_type_class(bit [15:0] qtype);
      msg_bytes.push_back(qtype[15:8]);
      msg_bytes.push_back(qtype[7:0]);
      msg_bytes.push_back(8'h00);
      msg_bytes.push_back(8'h01);
   endfunction

   function automatic void build_wellformed(bit compressed);
      bit [13:0] target;
      start_message(($urandom_range(0, 7) == 0) ? 16'd1 : 16'($urandom_range(1, 65535)));
      repeat ($urandom_range(0, 4)) add_random_label($urandom_range(1, 12));
      if (compressed) begin
         target = 14'(msg_bytes.size() + 2 + TYPE_CLASS_BYTES);
         add_pointer(target);
         add_type_class(16'($urandom));
         repeat ($urandom_range(1, 2)) add_random_label($urandom_range(1, 10));
         add_raw(8'h00);
      end else begin
         add_raw(8'h00);
         add_type_class(16'($urandom));
      end
      repeat ($urandom_range(0, 6)) add_raw(8'($urandom));
   endfunction

   function automatic void build_random_message();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind == 7) begin
         msg_bytes.delete();
         repeat ($urandom_range(1, 40)) add_raw(8'($urandom));
      end else begin
         build_wellformed(kind == 5 || kind == 6);
         if (kind == 8) begin
            repeat ($urandom_range(1, msg_bytes.size() - 1)) void'(msg_bytes.pop_back());
         end else if (kind == 9) begin
            msg_bytes[$urandom_range(HEADER_BYTES, msg_bytes.size() - 1)] = 8'($urandom);
         end
      end
   endfunction

   task automatic send_byte(input bit [7:0] value, input bit last);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_pkt_byte <= value;
      req_last_byte <= last;
      do @(posedge clock); while (busy !== 1'b0);
      record_byte(value, last);
   endtask

   task automatic send_message();
      for (int i = 0; i < msg_bytes.size(); i++) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (expected_chunks.size() != 0);
   endtask

   task automatic check_header_rejects();
      max_gap = 6;
      msg_bytes.delete();
      add_raw(8'h00);
      send_message();
      start_message(16'd1);
      void'(msg_bytes.pop_back());
      send_message();
      start_message(16'd0);
      add_label("zero");
      add_raw(8'h00);
      add_type_class(16'd1);
      send_message();
      hold_until_drained();
   endtask

   task automatic check_plain_names();
      max_gap = 0;
      start_message(16'd1);
      add_raw(8'h00);
      add_type_class(16'hFFFF);
      send_message();
      start_message(16'hFFFF);
      add_label("WwW");
      add_label("Example");
      add_label("COM");
      add_raw(8'h00);
      add_type_class(16'd28);
      send_message();
      // letter boundaries and non-printing bytes inside a label
      start_message(16'd2);
      add_raw(8'd8);
      add_raw(8'h00);
      add_label("@AZ[`a");
      void'(msg_bytes.pop_back());
      msg_bytes[msg_bytes.size() - 7] = "@";
      msg_bytes.delete(msg_bytes.size() - 7);
      add_raw("a");
      add_raw(8'hFF);
      add_label("z");
      add_raw(8'h00);
      add_type_class(16'd15);
      send_message();
      start_message(16'h0100);
      add_label("abcdefgh");
      add_raw(8'h00);
      add_type_class(16'd16);
      send_message();
      max_gap = 6;
      start_message(16'd1);
      add_random_label(MAX_LABEL_LEN);
      add_raw(8'h00);
      add_type_class(16'd255);
      send_message();
      hold_until_drained();
   endtask

   task automatic check_compression();
      max_gap = 3;
      start_message(16'd1);
      add_label("mail");
      add_pointer(14'(HEADER_BYTES + 7 + TYPE_CLASS_BYTES));
      add_type_class(16'd1);
      add_label("Example");
      add_label("ORG");
      add_raw(8'h00);
      send_message();
      for (int hops = JUMP_LIMIT; hops <= JUMP_LIMIT + 1; hops++) begin
         start_message(16'd1);
         for (int j = 1; j <= hops; j++) add_pointer(14'(HEADER_BYTES + 2 * j));
         add_label("a");
         add_raw(8'h00);
         send_message();
      end
      start_message(16'd1);
      add_pointer(14'(HEADER_BYTES));
      add_type_class(16'd1);
      send_message();
      start_message(16'd1);
      add_label("a");
      add_raw({PTR_TAG, 6'd0});
      send_message();
      start_message(16'd1);
      add_pointer(14'h3FFF);
      add_type_class(16'd1);
      send_message();
      hold_until_drained();
   endtask

   task automatic check_malformed_names();
      bit [7:0] bad_lengths [3];
      bad_lengths = '{8'h40, 8'h80, 8'hBF};
      max_gap = 2;
      foreach (bad_lengths[i]) begin
         start_message(16'd1);
         add_raw(bad_lengths[i]);
         add_label("abc");
         add_raw(8'h00);
         add_type_class(16'd1);
         send_message();
      end
      start_message(16'd1);
      add_raw(8'd10);
      add_label("abcd");
      send_message();
      start_message(16'd1);
      add_label("abc");
      send_message();
      start_message(16'd1);
      send_message();
      hold_until_drained();
   endtask

   task automatic check_truncated_question();
      max_gap = 6;
      start_message(16'd1);
      add_label("host");
      add_raw(8'h00);
      add_type_class(16'd1);
      void'(msg_bytes.pop_back());
      send_message();
      start_message(16'd1);
      add_label("host");
      add_raw(8'h00);
      add_type_class(16'h8001);
      send_message();
      start_message(16'd1);
      add_label("host");
      add_raw(8'h00);
      send_message();
      hold_until_drained();
   endtask

   task automatic check_name_capacity();
      max_gap = 1;
      for (int tail = MAX_LABEL_LEN - 2; tail <= MAX_LABEL_LEN - 1; tail++) begin
         start_message(16'd1);
         repeat (3) add_random_label(MAX_LABEL_LEN);
         add_random_label(tail);
         add_raw(8'h00);
         add_type_class(16'd1);
         send_message();
      end
      hold_until_drained();
   endtask

   task automatic check_overlong_message();
      max_gap = 1;
      start_message(16'd1);
      add_label("overlong");
      add_raw(8'h00);
      add_type_class(16'd6);
      while (msg_bytes.size() < PACKET_BYTES + 5) add_raw(8'($urandom));
      send_message();
      start_message(16'd1);
      add_label("after");
      add_raw(8'h00);
      add_type_class(16'd2);
      send_message();
      hold_until_drained();
   endtask

   task automatic check_random_traffic();
      int sent_bytes;
      sent_bytes = 0;
      while (sent_bytes < RANDOM_BYTES) begin
         max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
         build_random_message();
         sent_bytes += msg_bytes.size();
         send_message();
         if ($urandom_range(0, 7) == 0) hold_until_drained();
      end
      hold_until_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      check_header_rejects();
      check_plain_names();
      check_compression();
      check_malformed_names();
      check_truncated_question();
      check_name_capacity();
      check_overlong_message();
      check_random_traffic();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("dns_question_name_parser_unit_tb passed");
      end else begin
         $display("dns_question_name_parser_unit_tb failed");
      end
      $finish;
   end

endmodule
